/* rtl/core/nrlt_pkg.sv */
// Shared types and constants for the NMEA RMC local-time parser.
// Used by the front, queue, back and top-level modules; no dependencies.
package nrlt_pkg;

  localparam int MAX_FIELD_CHARS = 16;
  localparam int LEN_W = $clog2(MAX_FIELD_CHARS + 1);
  localparam int MIN_VALID_CHARS = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] ZONE_RESET = 4'd4;
  localparam logic [7:0] HOURS_HALF_DAY = 8'd12;
  localparam logic [7:0] DIGIT_RADIX = 8'd10;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_P = 8'h50;
  localparam logic [7:0] CHAR_R = 8'h52;
  localparam logic [7:0] CHAR_M = 8'h4D;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  typedef struct packed {
    logic       time_valid;
    logic [3:0] nib0;
    logic [3:0] nib1;
    logic [3:0] nib2;
    logic [3:0] nib3;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic full;
  } push_ctl_t;

  typedef struct packed {
    logic pop;
    logic not_empty;
  } pop_ctl_t;

endpackage

/* rtl/core/nrlt_front.sv */
// Front end: accepts received bytes, matches the sentence header and
// captures the time field, pushing one command per closing comma.
// Depends on nrlt_pkg.
module nrlt_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               rx_byte,
  input  logic                     q_full,
  output logic                     q_push,
  output nrlt_pkg::cmd_t           q_cmd
);

  typedef enum logic [8:0] {
    HUNT       = 9'b000000001,
    HDR_G      = 9'b000000010,
    HDR_P      = 9'b000000100,
    HDR_R      = 9'b000001000,
    HDR_M      = 9'b000010000,
    HDR_C      = 9'b000100000,
    HDR_COMMA  = 9'b001000000,
    COLLECT    = 9'b010000000,
    SWALLOW    = 9'b100000000
  } phase_t;

  phase_t                     phase;
  phase_t                     phase_next;
  logic [nrlt_pkg::LEN_W-1:0] field_length;
  logic [nrlt_pkg::LEN_W-1:0] field_length_next;
  logic [3:0]                 nibbles [4];
  logic                       accept;
  logic                       is_comma;
  logic                       take_char;

  assign in_stall = q_full;
  assign accept = in_valid && !q_full;
  assign is_comma = (rx_byte == nrlt_pkg::CHAR_COMMA);
  assign take_char = (phase == COLLECT) && !is_comma &&
                     (field_length < nrlt_pkg::LEN_W'(nrlt_pkg::MAX_FIELD_CHARS));

  always_comb begin
    phase_next = phase;
    field_length_next = field_length;
    case (phase)
      HUNT: begin
        phase_next = (rx_byte == nrlt_pkg::CHAR_DOLLAR) ? HDR_G : HUNT;
      end
      HDR_G: begin
        phase_next = (rx_byte == nrlt_pkg::CHAR_G) ? HDR_P : HUNT;
      end
      HDR_P: begin
        phase_next = (rx_byte == nrlt_pkg::CHAR_P) ? HDR_R : HUNT;
      end
      HDR_R: begin
        phase_next = (rx_byte == nrlt_pkg::CHAR_R) ? HDR_M : HUNT;
      end
      HDR_M: begin
        phase_next = (rx_byte == nrlt_pkg::CHAR_M) ? HDR_C : HUNT;
      end
      HDR_C: begin
        phase_next = (rx_byte == nrlt_pkg::CHAR_C) ? HDR_COMMA : HUNT;
      end
      HDR_COMMA: begin
        field_length_next = '0;
        phase_next = is_comma ? COLLECT : HUNT;
      end
      COLLECT: begin
        if (is_comma) begin
          field_length_next = '0;
          phase_next = SWALLOW;
        end else if (take_char) begin
          field_length_next = field_length + 1'b1;
        end
      end
      SWALLOW: begin
        phase_next = HUNT;
      end
      default: begin
        phase_next = (rx_byte == nrlt_pkg::CHAR_DOLLAR) ? HDR_G : HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= HUNT;
      field_length <= '0;
    end else if (accept) begin
      phase <= phase_next;
      field_length <= field_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && take_char && (field_length < nrlt_pkg::LEN_W'(4))) begin
      nibbles[field_length[1:0]] <= rx_byte[3:0];
    end
  end

  assign q_push = accept && (phase == COLLECT) && is_comma;

  always_comb begin
    q_cmd.time_valid = (field_length >= nrlt_pkg::LEN_W'(nrlt_pkg::MIN_VALID_CHARS));
    q_cmd.nib0 = nibbles[0];
    q_cmd.nib1 = nibbles[1];
    q_cmd.nib2 = nibbles[2];
    q_cmd.nib3 = nibbles[3];
  end

endmodule

/* rtl/core/nrlt_queue.sv */
// Short command queue between the front end and the result stage.
// Depends on nrlt_pkg.
module nrlt_queue (
  input  logic                clk,
  input  logic                rst,
  input  nrlt_pkg::push_ctl_t push_ctl_in,
  input  nrlt_pkg::cmd_t      push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output nrlt_pkg::cmd_t      head
);

  nrlt_pkg::cmd_t                entries [nrlt_pkg::QUEUE_DEPTH];
  logic [nrlt_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [nrlt_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [nrlt_pkg::QUEUE_CW-1:0] count;
  logic                          do_push;
  logic                          do_pop;

  assign full = (count == nrlt_pkg::QUEUE_CW'(nrlt_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head = entries[rd_ptr];
  assign do_push = push_ctl_in.push && !push_ctl_in.full;
  assign do_pop = pop && not_empty;

  function automatic logic [nrlt_pkg::QUEUE_AW-1:0] bump(
    input logic [nrlt_pkg::QUEUE_AW-1:0] ptr
  );
    if (ptr == nrlt_pkg::QUEUE_AW'(nrlt_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return ptr + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* rtl/core/nrlt_back.sv */
// Result stage: turns a queued time command into local twelve-hour digits
// and holds the result beat in an output register. Depends on nrlt_pkg.
module nrlt_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [3:0]          cfg_wr_data,
  input  nrlt_pkg::cmd_t      cmd,
  output nrlt_pkg::pop_ctl_t  pop_ctl,
  input  logic                cmd_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                hour_tens,
  output logic [3:0]          hour_ones,
  output logic [3:0]          minute_tens,
  output logic [3:0]          minute_ones,
  output logic                time_valid
);

  logic [3:0] zone;
  logic [7:0] h0;
  logic [7:0] h1;
  logic [7:0] h2;
  logic [8:0] diff;
  logic [8:0] diff_less;
  logic       tens;
  logic       pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= nrlt_pkg::ZONE_RESET;
    end else if (cfg_wr_en) begin
      zone <= cfg_wr_data;
    end
  end

  always_comb begin
    h0 = 8'(cmd.nib0) * nrlt_pkg::DIGIT_RADIX + 8'(cmd.nib1);
    h1 = (h0 > nrlt_pkg::HOURS_HALF_DAY) ? h0 - nrlt_pkg::HOURS_HALF_DAY : h0;
    h2 = (h1 <= 8'(zone)) ? h1 + nrlt_pkg::HOURS_HALF_DAY : h1;
    diff = {1'b0, h2} - 9'(zone);
    diff_less = diff - 9'(nrlt_pkg::DIGIT_RADIX);
    tens = diff[8] || (diff[7:0] > 8'd9);
  end

  assign pop = cmd_ready && (!out_valid || !out_stall);
  assign pop_ctl.pop = pop;
  assign pop_ctl.not_empty = cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= pop || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cmd.time_valid) begin
        hour_tens <= tens;
        hour_ones <= tens ? diff_less[3:0] : diff[3:0];
        minute_tens <= cmd.nib2;
        minute_ones <= cmd.nib3;
        time_valid <= 1'b1;
      end else begin
        hour_tens <= 1'b0;
        hour_ones <= '0;
        minute_tens <= '0;
        minute_ones <= '0;
        time_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/nmea_rmc_local_time_parser_core.sv */
// NMEA RMC local-time parser, top level. Takes one byte beat per cycle while not stalled.
// Path: the command for a closing comma is written into the queue, then popped into the result output register.
// Throughput: one byte per cycle; the input stalls only while the two-entry queue is full.
// Reset (rst, synchronous, active high) returns to the header hunt, empties the queue,
// drops any pending result and sets the zone offset to four hours.
// Depends on nrlt_pkg, nrlt_front, nrlt_queue and nrlt_back.
module nmea_rmc_local_time_parser_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       hour_tens,
  output logic [3:0] hour_ones,
  output logic [3:0] minute_tens,
  output logic [3:0] minute_ones,
  output logic       time_valid
);

  nrlt_pkg::cmd_t      push_cmd;
  nrlt_pkg::cmd_t      head;
  nrlt_pkg::push_ctl_t push_ctl;
  nrlt_pkg::pop_ctl_t  pop_ctl;
  logic                q_full;
  logic                q_push;
  logic                q_not_empty;

  assign push_ctl.push = q_push;
  assign push_ctl.full = q_full;

  nrlt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  nrlt_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_ctl_in (push_ctl),
    .push_cmd    (push_cmd),
    .full        (q_full),
    .pop         (pop_ctl.pop),
    .not_empty   (q_not_empty),
    .head        (head)
  );

  nrlt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (head),
    .pop_ctl     (pop_ctl),
    .cmd_ready   (q_not_empty),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hour_tens   (hour_tens),
    .hour_ones   (hour_ones),
    .minute_tens (minute_tens),
    .minute_ones (minute_ones),
    .time_valid  (time_valid)
  );

endmodule
